// File: rtl/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// Shared types and codes for the edit distance engine.
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam logic [1:0] FUNC_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_APPEND_SECOND = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE       = 2'd2;

  localparam int unsigned DIST_W = 7;
  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_DONE
  } edc_state_e;

  typedef struct packed {
    logic valid;
    logic last;
  } tok_ctl_t;

endpackage

// File: rtl/edit_distance_engine_top.sv
// Append transactions may follow back to back.
// A compute transaction presents its result once the row tokens have walked through
// the chain of MAX_LEN cells (no tokens are issued if the first string is empty) and
// the output register is free; no input is taken until then. Reset clears both
// string lengths, the overflow flag and the output valid; stored characters are
// undefined until written.
// ----------------------------------------------------------------------------
// edit_distance_engine_top
// Levenshtein distance engine built as a systolic chain of column cells.
// ----------------------------------------------------------------------------
module edit_distance_engine_top import edc_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] distance, [7] zero
  output logic        m_axis_tuser    // [0] overflow
);

  localparam int unsigned DW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SW = (DW > DIST_W) ? DW : DIST_W;

  edc_state_e state_q, state_d;

  logic [DW-1:0] first_len_q;
  logic [DW-1:0] second_len_q;
  logic          dropped_q;
  logic [DW-1:0] k_q;
  logic [7:0]    first_mem [MAX_LEN];
  logic [7:0]    rd_data_q;
  tok_ctl_t      inj_ctl_q;
  logic [DW-1:0] inj_row_q;
  logic [DW-1:0] result_q;
  logic          m_valid_q;
  logic [DIST_W-1:0] m_dist_q;
  logic          m_ovf_q;

  logic          in_acc;
  logic          feed_issue;
  logic          feed_last;
  logic          start_calc;
  logic          out_load;
  logic          chain_done;
  logic [SW-1:0] res_ext;

  tok_ctl_t      tok_ctl [MAX_LEN+1];
  logic [7:0]    tok_ch  [MAX_LEN+1];
  logic [DW-1:0] tok_d   [MAX_LEN+1];

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign feed_last  = (k_q == (first_len_q - DW'(1)));
  assign chain_done = tok_ctl[MAX_LEN].valid && tok_ctl[MAX_LEN].last;
  assign start_calc = in_acc && (s_axis_tuser == FUNC_COMPUTE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_calc) begin
          state_d = (first_len_q == '0) ? ST_DONE : ST_FEED;
        end
      end
      ST_FEED: begin
        if (feed_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (chain_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    feed_issue    = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_FEED:  feed_issue    = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load      = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_len_q  <= '0;
      second_len_q <= '0;
      dropped_q    <= 1'b0;
      k_q          <= '0;
      inj_ctl_q    <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      inj_ctl_q <= '{valid: feed_issue, last: feed_last};
      if (in_acc && s_axis_tuser == FUNC_APPEND_FIRST) begin
        if (first_len_q < DW'(MAX_LEN)) begin
          first_len_q <= first_len_q + DW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (in_acc && s_axis_tuser == FUNC_APPEND_SECOND) begin
        if (second_len_q < DW'(MAX_LEN)) begin
          second_len_q <= second_len_q + DW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (start_calc) begin
        k_q <= '0;
      end else if (feed_issue) begin
        k_q <= k_q + DW'(1);
      end
      if (out_load) begin
        m_valid_q    <= 1'b1;
        first_len_q  <= '0;
        second_len_q <= '0;
        dropped_q    <= 1'b0;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == FUNC_APPEND_FIRST && first_len_q < DW'(MAX_LEN)) begin
      first_mem[first_len_q[AW-1:0]] <= s_axis_tdata;
    end
    rd_data_q <= first_mem[k_q[AW-1:0]];
    inj_row_q <= k_q + DW'(1);
    if (start_calc) begin
      result_q <= second_len_q;
    end else if (chain_done) begin
      result_q <= tok_d[MAX_LEN];
    end
    if (out_load) begin
      m_dist_q <= (res_ext > SW'(DIST_MAX)) ? DIST_MAX : res_ext[DIST_W-1:0];
      m_ovf_q  <= dropped_q;
    end
  end

  assign res_ext = SW'(result_q);

  assign tok_ctl[0] = inj_ctl_q;
  assign tok_ch[0]  = rd_data_q;
  assign tok_d[0]   = inj_row_q;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    edc_cell #(
      .DW  (DW),
      .IDX (g + 1)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (start_calc),
      .enable_i  (DW'(g + 1) <= second_len_q),
      .load_i    (in_acc && s_axis_tuser == FUNC_APPEND_SECOND
                  && second_len_q == DW'(g)),
      .load_ch_i (s_axis_tdata),
      .ctl_i     (tok_ctl[g]),
      .ch_i      (tok_ch[g]),
      .d_i       (tok_d[g]),
      .ctl_o     (tok_ctl[g+1]),
      .ch_o      (tok_ch[g+1]),
      .d_o       (tok_d[g+1])
    );
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_dist_q};
  assign m_axis_tuser  = m_ovf_q;

  a_done_only_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_done |-> state_q == ST_DRAIN)
    else $error("row token finished outside of drain");

  a_feed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FEED |-> k_q < first_len_q)
    else $error("feed index beyond first string");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside of done");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_len_q <= DW'(MAX_LEN) && second_len_q <= DW'(MAX_LEN))
    else $error("string length beyond capacity");

endmodule

// File: rtl/edc_cell.sv
// ----------------------------------------------------------------------------
// edc_cell
// One column of the dynamic programme: holds one character of the second
// string and the last row value of its column, and passes row tokens right.
// ----------------------------------------------------------------------------
module edc_cell import edc_pkg::*; #(
  parameter int unsigned DW  = 7,
  parameter int unsigned IDX = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          enable_i,
  input  logic          load_i,
  input  logic [7:0]    load_ch_i,
  input  tok_ctl_t      ctl_i,
  input  logic [7:0]    ch_i,
  input  logic [DW-1:0] d_i,
  output tok_ctl_t      ctl_o,
  output logic [7:0]    ch_o,
  output logic [DW-1:0] d_o
);

  logic [7:0]    char_q;
  logic [DW-1:0] up_q;
  logic [DW-1:0] diag_q;
  logic [DW:0]   up_inc;
  logic [DW:0]   left_inc;
  logic [DW:0]   sub_cost;
  logic [DW:0]   min_a;
  logic [DW:0]   min_b;
  logic [DW-1:0] res;

  always_comb begin
    up_inc   = {1'b0, up_q} + (DW+1)'(1);
    left_inc = {1'b0, d_i} + (DW+1)'(1);
    sub_cost = {1'b0, diag_q} + ((ch_i == char_q) ? (DW+1)'(0) : (DW+1)'(1));
    min_a    = (up_inc < left_inc) ? up_inc : left_inc;
    min_b    = (min_a < sub_cost) ? min_a : sub_cost;
    res      = min_b[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      char_q <= load_ch_i;
    end
    if (start_i) begin
      up_q   <= DW'(IDX);
      diag_q <= DW'(IDX - 1);
    end else if (ctl_i.valid && enable_i) begin
      up_q   <= res;
      diag_q <= d_i;
    end
    ch_o <= ch_i;
    d_o  <= enable_i ? res : d_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

endmodule

// File: test/edit_distance_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_engine_top_tb
// Self-checking bench for the Levenshtein distance engine. Strings are loaded
// through the input stream, and each compute transaction is predicted by a
// Wagner-Fischer calculation held in the bench. The stimulus covers empty,
// equal, edited, random and overflowing strings, with random gaps and
// backpressure on both streams.
// ----------------------------------------------------------------------------
module edit_distance_engine_top_tb import edc_pkg::*;;

  localparam int unsigned STR_DEPTH   = 64;
  localparam int unsigned IDLE_PCT    = 8;
  localparam int unsigned ITEM_TARGET = 1700;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] ch;
  } char_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } dist_result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic [1:0] s_axis_tuser  = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;

  char_item_t   item_q[$];
  dist_result_t dist_q[$];
  char_item_t   drv_item;

  logic [7:0] first_str[STR_DEPTH];
  logic [7:0] second_str[STR_DEPTH];
  int         first_n;
  int         second_n;
  logic       dropped;

  logic hold_rx = 1'b0;
  logic quiet   = 1'b0;

  int errors        = 0;
  int loads_seen    = 0;
  int results_seen  = 0;
  int overflow_seen = 0;
  int max_dist_seen = 0;
  int items_queued  = 0;

  edit_distance_engine_top #(
    .MAX_LEN(STR_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [DIST_W-1:0] levenshtein();
    int prev_row[STR_DEPTH+1];
    int cur_row[STR_DEPTH+1];
    int sub_cost;
    int best;
    for (int j = 0; j <= second_n; j++) prev_row[j] = j;
    for (int i = 1; i <= first_n; i++) begin
      cur_row[0] = i;
      for (int j = 1; j <= second_n; j++) begin
        sub_cost = prev_row[j-1] + ((first_str[i-1] == second_str[j-1]) ? 0 : 1);
        best = prev_row[j] + 1;
        if (cur_row[j-1] + 1 < best) best = cur_row[j-1] + 1;
        if (sub_cost < best) best = sub_cost;
        cur_row[j] = best;
      end
      for (int j = 0; j <= second_n; j++) prev_row[j] = cur_row[j];
    end
    if (prev_row[second_n] > int'(DIST_MAX)) return DIST_MAX;
    return prev_row[second_n][DIST_W-1:0];
  endfunction

  function automatic void string_engine_step(logic [1:0] func, logic [7:0] ch);
    dist_result_t res;
    case (func)
      FUNC_APPEND_FIRST: begin
        if (first_n < STR_DEPTH) begin
          first_str[first_n] = ch;
          first_n++;
        end else begin
          dropped = 1'b1;
        end
      end
      FUNC_APPEND_SECOND: begin
        if (second_n < STR_DEPTH) begin
          second_str[second_n] = ch;
          second_n++;
        end else begin
          dropped = 1'b1;
        end
      end
      FUNC_COMPUTE: begin
        res.distance = levenshtein();
        res.overflow = dropped;
        dist_q.push_back(res);
        first_n  = 0;
        second_n = 0;
        dropped  = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Input driver: a new transaction is presented once the previous one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (item_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        drv_item = item_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= drv_item.ch;
        s_axis_tuser  <= drv_item.func;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_rx) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: check the output transaction first, then predict from the input one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (dist_q.size() == 0) begin
          $error("result with no compute pending: distance %0d, overflow %0d",
                 m_axis_tdata[DIST_W-1:0], m_axis_tuser);
          errors++;
        end else begin
          dist_result_t exp_res;
          exp_res = dist_q.pop_front();
          if (m_axis_tdata[DIST_W-1:0] !== exp_res.distance) begin
            $error("distance mismatch: expected %0d, got %0d",
                   exp_res.distance, m_axis_tdata[DIST_W-1:0]);
            errors++;
          end
          if (m_axis_tdata[7] !== 1'b0) begin
            $error("tdata pad mismatch: expected 0, got %b", m_axis_tdata[7]);
            errors++;
          end
          if (m_axis_tuser !== exp_res.overflow) begin
            $error("overflow mismatch: expected %0d, got %0d",
                   exp_res.overflow, m_axis_tuser);
            errors++;
          end
          if (exp_res.overflow) overflow_seen++;
          if (int'(exp_res.distance) > max_dist_seen) max_dist_seen = int'(exp_res.distance);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == FUNC_APPEND_FIRST || s_axis_tuser == FUNC_APPEND_SECOND)
          loads_seen++;
        string_engine_step(s_axis_tuser, s_axis_tdata);
      end
    end
  end

  initial begin
    while (results_seen < 30) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (500) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    while (results_seen < 60) @(posedge clk_i);
    quiet <= 1'b1;
    while (results_seen < 90) @(posedge clk_i);
    quiet <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_item(logic [1:0] func, logic [7:0] ch);
    char_item_t it;
    it.func = func;
    it.ch   = ch;
    item_q.push_back(it);
    items_queued++;
  endtask

  function automatic logic [7:0] pick_char(bit narrow);
    if (narrow) return 8'h61 + 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // Appends of the two strings are interleaved at random, with the odd unused
  // function code thrown in as noise, and closed by a compute.
  task automatic emit_job(logic [7:0] s1[$], logic [7:0] s2[$]);
    int i1;
    int i2;
    i1 = 0;
    i2 = 0;
    while (i1 < s1.size() || i2 < s2.size()) begin
      if ($urandom_range(99) < 3) push_item(FUNC_UNUSED, pick_char(1'b0));
      if (i2 >= s2.size() || (i1 < s1.size() && $urandom_range(1) == 0)) begin
        push_item(FUNC_APPEND_FIRST, s1[i1]);
        i1++;
      end else begin
        push_item(FUNC_APPEND_SECOND, s2[i2]);
        i2++;
      end
    end
    push_item(FUNC_COMPUTE, pick_char(1'b0));
  endtask

  task automatic random_job(int forced);
    logic [7:0] s1[$];
    logic [7:0] s2[$];
    int mode;
    int n1;
    int n2;
    int pos;
    mode = $urandom_range(99);
    n1 = $urandom_range(10);
    n2 = $urandom_range(10);
    case (forced)
      0: begin n1 = 65; n2 = 3; mode = 90; end
      1: begin n1 = 2; n2 = 66; mode = 90; end
      2: begin n1 = 64; n2 = 0; mode = 90; end
      3: begin n1 = 64; n2 = 64; mode = 100; end
      default: begin
        if (mode >= 95) begin
          n1 = $urandom_range(70, 40);
          n2 = $urandom_range(70, 40);
        end
      end
    endcase
    if (mode == 100) begin
      // Every pair differs, so the distance reaches the full string length.
      for (int k = 0; k < n1; k++) s1.push_back(8'h00);
      for (int k = 0; k < n2; k++) s2.push_back(8'hFF);
    end else if (mode >= 60 && mode < 80) begin
      n1 = $urandom_range(16);
      for (int k = 0; k < n1; k++) s1.push_back(pick_char(1'b0));
      s2 = s1;
      repeat ($urandom_range(3)) begin
        pos = $urandom_range(s2.size());
        case ($urandom_range(2))
          0: s2.insert(pos, pick_char(1'b0));
          1: if (pos < s2.size()) s2.delete(pos);
          default: if (pos < s2.size()) s2[pos] = pick_char(1'b0);
        endcase
      end
    end else begin
      for (int k = 0; k < n1; k++) s1.push_back(pick_char(mode < 60));
      for (int k = 0; k < n2; k++) s2.push_back(pick_char(mode < 60));
    end
    emit_job(s1, s2);
  endtask

  initial begin
    int job;
    first_n  = 0;
    second_n = 0;
    dropped  = 1'b0;

    push_item(FUNC_COMPUTE, 8'h00);
    push_item(FUNC_APPEND_FIRST, 8'h00);
    push_item(FUNC_COMPUTE, 8'hFF);
    push_item(FUNC_APPEND_SECOND, 8'hFF);
    push_item(FUNC_COMPUTE, 8'h00);
    push_item(FUNC_APPEND_FIRST, 8'h00);
    push_item(FUNC_APPEND_FIRST, 8'hFF);
    push_item(FUNC_UNUSED, 8'hAA);
    push_item(FUNC_APPEND_SECOND, 8'hFF);
    push_item(FUNC_APPEND_SECOND, 8'h00);
    push_item(FUNC_COMPUTE, 8'h55);
    push_item(FUNC_APPEND_FIRST, 8'h5A);
    push_item(FUNC_APPEND_SECOND, 8'h5A);
    push_item(FUNC_UNUSED, 8'h00);
    push_item(FUNC_COMPUTE, 8'hFF);
    push_item(FUNC_UNUSED, 8'hFF);
    push_item(FUNC_COMPUTE, 8'h00);
    push_item(FUNC_APPEND_FIRST, 8'h80);
    push_item(FUNC_APPEND_SECOND, 8'h7F);
    push_item(FUNC_COMPUTE, 8'hA5);

    job = 0;
    while (items_queued < ITEM_TARGET) begin
      random_job(job);
      job++;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Loaded %0d characters and checked %0d distances (%0d with dropped",
             loads_seen, results_seen, overflow_seen);
    $display("characters), largest distance %0d.", max_dist_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/edc_pkg.sv
rtl/edc_cell.sv
rtl/edit_distance_engine_top.sv
test/edit_distance_engine_top_tb.sv
